// File: rtl/bta_pkg.sv
// Package for the boundary-tag heap allocator.
// Heap geometry, operation codes and the request/result payload types.
package bta_pkg;
  localparam int HEAP_BYTES = 127;
  localparam int ADDR_W = 7;
  localparam int DATA_W = 8;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] request_size;
    logic [6:0] payload_index;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [6:0] granted_index;
    logic [7:0] read_data;
    logic       status;
  } rsp_t;
endpackage

// File: rtl/bta_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on bta_pkg for the payload types.
interface bta_req_if import bta_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/bta_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator: one request at a time over a 127-byte heap RAM (bta_ram, bta_pkg).
// A write or read touches one byte; allocate walks the block headers, then picks and splits;
// free clears the tags, zeroes the payload, then merges with free neighbours.
// Throughput: one request in flight; the next is accepted once its result is in the output register.
// Reset: synchronous; a clearing pass over every heap byte then writes the initial free block,
// during which no request is accepted.
module boundary_tag_heap_allocator import bta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bta_req_if.sink     req,
  bta_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_RD = 5'd2, S_RDW = 5'd3,
    S_WALK = 5'd4, S_WALKW = 5'd5, S_WALKC = 5'd6, S_SPLIT = 5'd7,
    S_FH = 5'd8, S_FHW = 5'd9, S_FHC = 5'd10, S_FZ = 5'd11,
    S_FN = 5'd12, S_FNW = 5'd13, S_FNC = 5'd14, S_FP = 5'd15, S_FPW = 5'd16,
    S_FPH = 5'd17, S_FPHW = 5'd18, S_FPC = 5'd19, S_OUT = 5'd20,
    S_FOOT = 5'd21, S_FHW2 = 5'd22, S_FPR = 5'd23, S_FPF = 5'd24;

  logic [4:0] state, state_next;
  logic       fit_policy;
  req_t       cur, cur_next;
  logic [7:0] at, best, best_pay, sz, a1, foot, prv;
  logic [7:0] at_next, best_next, best_pay_next, sz_next, a1_next, foot_next, prv_next;
  logic [7:0] head_tag, prv_tag, head_tag_next, prv_tag_next;
  logic [2:0] step, step_next;
  logic [7:0] ptr, ptr_next;
  logic              m_we, m_we_next;
  logic [ADDR_W-1:0] m_addr, m_addr_next;
  logic [7:0]        m_wd, m_wd_next, m_rd;
  rsp_t       res, res_next;   // result being built
  rsp_t       out, out_next;   // result register on the rsp channel
  logic       out_v, out_v_next;
  logic [7:0] want, szw;

  bta_ram #(.WIDTH(DATA_W), .DEPTH(HEAP_BYTES)) u_heap (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.payload = out;

  always_ff @(posedge clk) begin
    if (rst) fit_policy <= 1'b0;
    else if (cfg_we) fit_policy <= cfg_wdata;
  end

  assign want = {1'b0, cur.request_size};
  // size field of the tag byte on the RAM read port
  assign szw = {1'b0, m_rd[7:1]};

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    out_v_next = out_v;
    out_next = out;
    res_next = res;
    cur_next = cur;
    at_next = at;
    best_next = best;
    best_pay_next = best_pay;
    sz_next = sz;
    a1_next = a1;
    foot_next = foot;
    prv_next = prv;
    head_tag_next = head_tag;
    prv_tag_next = prv_tag;
    step_next = step;
    m_we_next = 1'b0;
    m_addr_next = m_addr;
    m_wd_next = m_wd;
    if (rsp.ready) out_v_next = 1'b0;
    unique case (state)
      S_CLR: begin
        // one write per cycle: tags at both ends, zero payload between
        m_we_next = 1'b1;
        m_addr_next = ptr[6:0];
        m_wd_next = (ptr == 8'd0 || ptr == 8'(HEAP_BYTES - 1)) ?
                    8'(HEAP_BYTES << 1) : 8'd0;
        if (ptr == 8'(HEAP_BYTES - 1)) state_next = S_IDLE;
        ptr_next = ptr + 8'd1;
      end
      S_IDLE: if (req.valid) begin
        cur_next = req.payload;
        res_next = '0;
        unique case (req.payload.mode)
          MODE_ALLOC: begin
            if (req.payload.request_size == 7'd0) begin
              res_next.status = 1'b1;
              state_next = S_OUT;
            end else begin
              at_next = '0;
              best_next = 8'(HEAP_BYTES);
              best_pay_next = 8'hFF;
              state_next = S_WALK;
            end
          end
          MODE_FREE: begin
            // index 0 or past the last header can never name a block
            if (req.payload.payload_index == 7'd0 ||
                req.payload.payload_index == 7'(HEAP_BYTES)) state_next = S_OUT;
            else begin
              at_next = {1'b0, req.payload.payload_index} - 8'd1;
              state_next = S_FH;
            end
          end
          MODE_WRITE: begin
            if (req.payload.payload_index != 7'(HEAP_BYTES)) begin
              m_we_next = 1'b1;
              m_addr_next = req.payload.payload_index;
              m_wd_next = req.payload.write_data;
            end
            state_next = S_OUT;
          end
          MODE_READ: begin
            m_addr_next = req.payload.payload_index;
            state_next = S_RD;
          end
        endcase
      end
      S_RD: state_next = S_RDW;
      S_RDW: begin
        if (cur.payload_index != 7'(HEAP_BYTES)) res_next.read_data = m_rd;
        state_next = S_OUT;
      end
      // block walk: header read through the registered address and the RAM's registered read, then evaluate
      S_WALK: begin
        if (at >= 8'(HEAP_BYTES)) state_next = S_WALKC;
        else begin
          m_addr_next = at[6:0];
          state_next = S_WALKW;
        end
      end
      S_WALKW: state_next = S_FOOT;
      S_FOOT: begin
        // zero size tag ends the walk
        if (szw == 8'd0) state_next = S_WALKC;
        else begin
          if (!m_rd[0] && szw >= 8'd2 && (at + szw) <= 8'(HEAP_BYTES) &&
              (szw - 8'd2) >= want) begin
            if (!fit_policy) begin
              best_next = at;
              state_next = S_WALKC;
            end else begin
              // strict compare keeps the lowest address on a tie
              if ((szw - 8'd2) < best_pay || best_pay == 8'hFF) begin
                best_next = at;
                best_pay_next = szw - 8'd2;
              end
              state_next = S_WALK;
            end
          end else state_next = S_WALK;
          at_next = at + szw;
        end
      end
      S_WALKC: begin
        if (best >= 8'(HEAP_BYTES)) begin
          res_next.status = 1'b1;
          state_next = S_OUT;
        end else begin
          m_addr_next = best[6:0];
          step_next = 3'd0;
          at_next = best;
          state_next = S_SPLIT;
        end
      end
      // reread the chosen header, then write two or four tags
      S_SPLIT: begin
        step_next = step + 3'd1;
        unique case (step)
          3'd0: ;
          3'd1: sz_next = szw;
          3'd2: begin
            m_we_next = 1'b1;
            m_addr_next = at[6:0];
            if (sz - want >= 8'd3) begin
              m_wd_next = {want[6:0] + 7'd2, 1'b1};
            end else begin
              // too small to split: just mark the whole block allocated
              m_wd_next = {sz[6:0], 1'b1};
              step_next = 3'd6;
            end
          end
          3'd3: begin
            m_we_next = 1'b1;
            m_addr_next = 7'(at + want + 8'd1);
            m_wd_next = {want[6:0] + 7'd2, 1'b1};
          end
          3'd4: begin
            m_we_next = 1'b1;
            m_addr_next = 7'(at + want + 8'd2);
            m_wd_next = {7'(sz - want - 8'd2), 1'b0};
          end
          3'd5: begin
            m_we_next = 1'b1;
            m_addr_next = 7'(at + sz - 8'd1);
            m_wd_next = {7'(sz - want - 8'd2), 1'b0};
            res_next.granted_index = 7'(at + 8'd1);
            state_next = S_OUT;
          end
          default: begin
            m_we_next = 1'b1;
            m_addr_next = 7'(at + sz - 8'd1);
            m_wd_next = {sz[6:0], 1'b1};
            res_next.granted_index = 7'(at + 8'd1);
            state_next = S_OUT;
          end
        endcase
      end
      // free: header check and clear
      S_FH: begin
        m_addr_next = at[6:0];
        state_next = S_FHW;
      end
      S_FHW: state_next = S_FHW2;
      S_FHW2: begin
        sz_next = szw;
        if (szw < 8'd2 || at + szw > 8'(HEAP_BYTES)) state_next = S_OUT;
        else begin
          foot_next = at + szw - 8'd1;
          head_tag_next = {m_rd[7:1], 1'b0};
          m_we_next = 1'b1;
          m_addr_next = at[6:0];
          m_wd_next = {m_rd[7:1], 1'b0};
          ptr_next = at + 8'd1;
          state_next = S_FHC;
        end
      end
      S_FHC: begin
        // footer keeps its own size field; only its allocated bit is cleared
        m_addr_next = foot[6:0];
        state_next = S_FZ;
        step_next = 3'd0;
      end
      S_FZ: begin
        if (step == 3'd0) step_next = 3'd1;
        else if (step == 3'd1) begin
          m_we_next = 1'b1;
          m_addr_next = foot[6:0];
          m_wd_next = {m_rd[7:1], 1'b0};
          step_next = 3'd2;
        end else if (ptr < foot) begin
          // payload zeroing, one byte per cycle
          m_we_next = 1'b1;
          m_addr_next = ptr[6:0];
          m_wd_next = 8'd0;
          ptr_next = ptr + 8'd1;
        end else state_next = S_FN;
      end
      // merge with a free next block
      S_FN: begin
        a1_next = at + sz;
        if (at + sz < 8'(HEAP_BYTES)) begin
          m_addr_next = 7'(at + sz);
          state_next = S_FNW;
        end else state_next = S_FP;
      end
      S_FNW: state_next = S_FNC;
      S_FNC: begin
        if (!m_rd[0] && szw >= 8'd1 && a1 + szw <= 8'(HEAP_BYTES)) begin
          // tag sum wraps at 8 bits
          head_tag_next = head_tag + m_rd;
          foot_next = a1 + szw - 8'd1;
          m_we_next = 1'b1;
          m_addr_next = at[6:0];
          m_wd_next = head_tag + m_rd;
          state_next = S_FPC;
        end else state_next = S_FP;
      end
      S_FPC: begin
        m_we_next = 1'b1;
        m_addr_next = foot[6:0];
        m_wd_next = head_tag;
        state_next = S_FP;
      end
      // merge with a free previous block, found through its footer
      S_FP: begin
        if (at == 8'd0) state_next = S_OUT;
        else begin
          m_addr_next = 7'(at - 8'd1);
          state_next = S_FPW;
        end
      end
      S_FPW: state_next = S_FPH;
      S_FPH: begin
        if (szw >= 8'd1 && szw <= at) begin
          prv_next = at - szw;
          m_addr_next = 7'(at - szw);
          state_next = S_FPHW;
        end else state_next = S_OUT;
      end
      S_FPHW: state_next = S_FPR;
      S_FPR: begin
        if (!m_rd[0]) begin
          prv_tag_next = m_rd + head_tag;
          m_we_next = 1'b1;
          m_addr_next = prv[6:0];
          m_wd_next = m_rd + head_tag;
          state_next = S_FPF;
        end else state_next = S_OUT;
      end
      S_FPF: begin
        m_we_next = 1'b1;
        m_addr_next = foot[6:0];
        m_wd_next = prv_tag;
        state_next = S_OUT;
      end
      // hand the result to the output register once it is free
      S_OUT: if (!out_v || rsp.ready) begin
        out_v_next = 1'b1;
        out_next = res;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ptr <= '0;
      out_v <= 1'b0;
      m_we <= 1'b0;
      m_addr <= '0;
      m_wd <= '0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      out_v <= out_v_next;
      out <= out_next;
      res <= res_next;
      cur <= cur_next;
      at <= at_next;
      best <= best_next;
      best_pay <= best_pay_next;
      sz <= sz_next;
      a1 <= a1_next;
      foot <= foot_next;
      prv <= prv_next;
      head_tag <= head_tag_next;
      prv_tag <= prv_tag_next;
      step <= step_next;
      m_we <= m_we_next;
      m_addr <= m_addr_next;
      m_wd <= m_wd_next;
    end
  end

`ifndef SYNTHESIS
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
    else $error("result changed while waiting");
  a_no_grant_fail: assert property (@(posedge clk) disable iff (rst)
    out_v |-> !(out.status && out.granted_index != 7'd0)) else $error("grant with fail");
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !req.ready) else $error("request accepted while clearing");
`endif
endmodule
